// File: hw/rtl/ntrc_pkg.sv
// ----------------------------------------------------------------------------
// ntrc_pkg: shared types and constants for the ns / tick rate converter
// Holds the per-word control bundle that rides down the divider chain and
// the fixed constants of the conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package ntrc_pkg;

  // nanoseconds in one second
  localparam logic [63:0] NS_PER_SEC = 64'd1000000000;
  // largest leftover tick count whose nanosecond product fits 64 bits
  localparam logic [63:0] LEFTOVER_MAX = 64'd18446744073;
  // product width of the padded 64 x 64 multiply
  localparam int PROD_BITS = 128;
  localparam int HALF_BITS = 32;
  // configuration register width
  localparam int CFG_BITS = 40;
  localparam logic [CFG_BITS-1:0] RATE_RESET = 40'd1000000000;

  localparam int VALUE_BITS_DEF = 64;
  localparam int RATE_BITS_DEF = 40;

  // direction codes
  localparam logic OP_NS_TO_TICKS = 1'b0;
  localparam logic OP_TICKS_TO_NS = 1'b1;

  // control that travels with each word
  typedef struct packed {
    logic valid;
    logic op;
    logic inf;   // infinite timeout, passes through
    logic hz0;   // rate is zero
    logic ovf;   // quotient does not fit the value width
  } ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/ntrc_front.sv
// ----------------------------------------------------------------------------
// ntrc_front: multiply and setup stages ahead of the divider chain
// Forms numerator = amount * multiplier (+ divisor - 1 when rounding up),
// checks whether the quotient overflows and splits the numerator for the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module ntrc_front
  import ntrc_pkg::*;
#(
  parameter int VB = VALUE_BITS_DEF,
  parameter int RB = RATE_BITS_DEF,
  parameter int OW = (RATE_BITS_DEF > 30) ? RATE_BITS_DEF : 30
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  input  wire logic [VB-1:0] in_amount,
  input  wire logic [RB-1:0] hz,
  output ctl_t               ctl_o,
  output logic [OW-1:0]      rem_a_o,
  output logic [VB-1:0]      num_a_o,
  output logic [OW-1:0]      div_a_o,
  output logic [VB-1:0]      num_b_o,
  output logic [RB-1:0]      hz_o
);

  // stage 1: partial products
  ctl_t                 s1_ctl;
  logic [63:0]          p00, p01, p10, p11;
  logic [OW-1:0]        s1_div;
  logic [VB-1:0]        s1_amt;
  logic [RB-1:0]        s1_hz;
  logic [63:0]          a64, b64;
  logic [OW-1:0]        mult_b, div_sel;

  always_comb begin
    a64     = 64'(in_amount);
    mult_b  = (in_op == OP_NS_TO_TICKS) ? OW'(hz) : OW'(NS_PER_SEC);
    div_sel = (in_op == OP_NS_TO_TICKS) ? OW'(NS_PER_SEC) : OW'(hz);
    b64     = 64'(mult_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (advance) begin
      s1_ctl.valid <= in_valid;
      s1_ctl.op    <= in_op;
      s1_ctl.inf   <= (in_op == OP_NS_TO_TICKS) && (in_amount == {VB{1'b1}});
      s1_ctl.hz0   <= (hz == '0);
      s1_ctl.ovf   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p00    <= a64[HALF_BITS-1:0] * b64[HALF_BITS-1:0];
      p01    <= a64[HALF_BITS-1:0] * b64[63:HALF_BITS];
      p10    <= a64[63:HALF_BITS] * b64[HALF_BITS-1:0];
      p11    <= a64[63:HALF_BITS] * b64[63:HALF_BITS];
      s1_div <= div_sel;
      s1_amt <= in_amount;
      s1_hz  <= hz;
    end
  end

  // stage 2: sum partials, add rounding bias
  ctl_t                 s2_ctl;
  logic [PROD_BITS-1:0] s2_num;
  logic [OW-1:0]        s2_div;
  logic [VB-1:0]        s2_amt;
  logic [RB-1:0]        s2_hz;
  logic [PROD_BITS-1:0] bias;

  always_comb begin
    bias = (s1_ctl.op == OP_NS_TO_TICKS) ? PROD_BITS'(s1_div) - PROD_BITS'(1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (advance) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_num <= {p11, p00} + (PROD_BITS'(p01) << HALF_BITS)
              + (PROD_BITS'(p10) << HALF_BITS) + bias;
      s2_div <= s1_div;
      s2_amt <= s1_amt;
      s2_hz  <= s1_hz;
    end
  end

  // stage 3: overflow check and split
  logic [PROD_BITS-1:0] num_hi;
  ctl_t                 s3_ctl;

  always_comb begin
    num_hi     = s2_num >> VB;
    s3_ctl     = s2_ctl;
    s3_ctl.ovf = (num_hi >= PROD_BITS'(s2_div));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (advance) begin
      ctl_o <= s3_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_a_o <= s2_num[VB +: OW];
      num_a_o <= s2_num[VB-1:0];
      div_a_o <= s2_div;
      num_b_o <= s2_amt;
      hz_o    <= s2_hz;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ntrc_cell.sv
// ----------------------------------------------------------------------------
// ntrc_cell: one restoring division step for two lanes
// Lane A divides the product numerator, lane B divides the raw amount by the
// rate. Each cell shifts one dividend bit in and one quotient bit out.
// ----------------------------------------------------------------------------
`default_nettype none

module ntrc_cell
  import ntrc_pkg::*;
#(
  parameter int VB = VALUE_BITS_DEF,
  parameter int RB = RATE_BITS_DEF,
  parameter int OW = (RATE_BITS_DEF > 30) ? RATE_BITS_DEF : 30
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  ctl_t               ctl_i,
  input  wire logic [OW-1:0] rem_a_i,
  input  wire logic [VB-1:0] num_a_i,
  input  wire logic [OW-1:0] div_a_i,
  input  wire logic [RB-1:0] rem_b_i,
  input  wire logic [VB-1:0] num_b_i,
  input  wire logic [RB-1:0] hz_i,
  output ctl_t               ctl_o,
  output logic [OW-1:0]      rem_a_o,
  output logic [VB-1:0]      num_a_o,
  output logic [OW-1:0]      div_a_o,
  output logic [RB-1:0]      rem_b_o,
  output logic [VB-1:0]      num_b_o,
  output logic [RB-1:0]      hz_o
);

  logic [OW:0]   trial_a, diff_a;
  logic [RB:0]   trial_b, diff_b;
  logic          ge_a, ge_b;

  // trial subtract on both lanes
  always_comb begin
    trial_a = {rem_a_i, num_a_i[VB-1]};
    diff_a  = trial_a - {1'b0, div_a_i};
    ge_a    = (trial_a >= {1'b0, div_a_i});
    trial_b = {rem_b_i, num_b_i[VB-1]};
    diff_b  = trial_b - {1'b0, hz_i};
    ge_b    = (trial_b >= {1'b0, hz_i});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (advance) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem_a_o <= ge_a ? diff_a[OW-1:0] : trial_a[OW-1:0];
      num_a_o <= {num_a_i[VB-2:0], ge_a};
      div_a_o <= div_a_i;
      rem_b_o <= ge_b ? diff_b[RB-1:0] : trial_b[RB-1:0];
      num_b_o <= {num_b_i[VB-2:0], ge_b};
      hz_o    <= hz_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ntrc_out_buf.sv
// ----------------------------------------------------------------------------
// ntrc_out_buf: two-entry output buffer
// Decouples the chain from the output stall; the chain advances whenever the
// buffer is not full, so the input ready comes from a register.
// ----------------------------------------------------------------------------
`default_nettype none

module ntrc_out_buf
  import ntrc_pkg::*;
#(
  parameter int VB = VALUE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [VB-1:0] push_value,
  input  wire logic          push_sat,
  output logic               has_room,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [VB-1:0]      out_value,
  output logic               out_sat
);

  logic [1:0]    count;
  logic [VB-1:0] value1;
  logic          sat1;
  logic          pop;

  always_comb begin
    has_room  = (count != 2'd2);
    out_valid = (count != 2'd0);
    pop       = out_valid && out_ready;
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // entry shuffle
  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        out_value <= push_value;
        out_sat   <= push_sat;
      end else begin
        out_value <= value1;
        out_sat   <= sat1;
        value1    <= push_value;
        sat1      <= push_sat;
      end
    end else if (pop) begin
      out_value <= value1;
      out_sat   <= sat1;
    end else if (push) begin
      if (count == 2'd0) begin
        out_value <= push_value;
        out_sat   <= push_sat;
      end else begin
        value1 <= push_value;
        sat1   <= push_sat;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ns_tick_rate_converter_unit.sv
// ----------------------------------------------------------------------------
// ns_tick_rate_converter_unit: nanosecond / tick conversion at a set rate
// Pipelined multiply followed by a chain of restoring division cells.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                      tuser
//  s_*      in   amount                     opcode
//  m_*      out  converted                  saturated
//  cfg_*    in   tick_rate_hz (40 bits)     -
//
//  One word per cycle sustained while the output buffer has room. The path
//  runs through three multiply/setup stages, one division cell per quotient bit,
//  and the output buffer. Reset clears valid bits and sets the rate to 1 GHz.
//  The chain holds while the two-entry output buffer is full; s_tready
//  is taken from the buffer occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module ns_tick_rate_converter_unit
  import ntrc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int RATE_BITS  = RATE_BITS_DEF,
  parameter int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [DATA_BITS-1:0] s_tdata,   // [VALUE_BITS-1:0] amount
  input  wire logic                 s_tuser,   // [0] opcode
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [DATA_BITS-1:0]      m_tdata,   // [VALUE_BITS-1:0] converted
  output logic                      m_tuser,   // [0] saturated
  input  wire logic                 cfg_we,
  input  wire logic [CFG_BITS-1:0]  cfg_data   // tick_rate_hz
);

  localparam int VB = VALUE_BITS;
  localparam int RB = RATE_BITS;
  localparam int OW = (RATE_BITS > 30) ? RATE_BITS : 30;

  // rate register
  logic [CFG_BITS-1:0] tick_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= RATE_RESET;
    end else if (cfg_we) begin
      tick_rate <= cfg_data;
    end
  end

  logic advance;
  assign s_tready = advance;

  // chain links
  ctl_t          ctl   [VB+1];
  logic [OW-1:0] rem_a [VB+1];
  logic [VB-1:0] num_a [VB+1];
  logic [OW-1:0] div_a [VB+1];
  logic [RB-1:0] rem_b [VB+1];
  logic [VB-1:0] num_b [VB+1];
  logic [RB-1:0] hz    [VB+1];

  ntrc_front #(.VB(VB), .RB(RB), .OW(OW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s_tvalid),
    .in_op     (s_tuser),
    .in_amount (s_tdata[VB-1:0]),
    .hz        (RB'(tick_rate)),
    .ctl_o     (ctl[0]),
    .rem_a_o   (rem_a[0]),
    .num_a_o   (num_a[0]),
    .div_a_o   (div_a[0]),
    .num_b_o   (num_b[0]),
    .hz_o      (hz[0])
  );

  assign rem_b[0] = '0;

  // one cell per quotient bit
  for (genvar i = 0; i < VB; i++) begin : g_cell
    ntrc_cell #(.VB(VB), .RB(RB), .OW(OW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .ctl_i   (ctl[i]),
      .rem_a_i (rem_a[i]),
      .num_a_i (num_a[i]),
      .div_a_i (div_a[i]),
      .rem_b_i (rem_b[i]),
      .num_b_i (num_b[i]),
      .hz_i    (hz[i]),
      .ctl_o   (ctl[i+1]),
      .rem_a_o (rem_a[i+1]),
      .num_a_o (num_a[i+1]),
      .div_a_o (div_a[i+1]),
      .rem_b_o (rem_b[i+1]),
      .num_b_o (num_b[i+1]),
      .hz_o    (hz[i+1])
    );
  end

  // final result select
  ctl_t          last;
  logic [VB-1:0] res_value;
  logic          res_sat;

  always_comb begin
    last = ctl[VB];
    if (last.op == OP_NS_TO_TICKS) begin
      if (last.inf) begin
        res_value = {VB{1'b1}};
        res_sat   = 1'b0;
      end else if (last.ovf) begin
        res_value = {VB{1'b1}};
        res_sat   = 1'b1;
      end else begin
        res_value = num_a[VB];
        res_sat   = 1'b0;
      end
    end else begin
      if (last.hz0 || last.ovf || (64'(rem_b[VB]) > LEFTOVER_MAX)) begin
        res_value = {VB{1'b1}};
        res_sat   = 1'b1;
      end else begin
        res_value = num_a[VB];
        res_sat   = 1'b0;
      end
    end
  end

  logic [VB-1:0] out_value;

  ntrc_out_buf #(.VB(VB)) u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (last.valid && advance),
    .push_value (res_value),
    .push_sat   (res_sat),
    .has_room   (advance),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (out_value),
    .out_sat    (m_tuser)
  );

  assign m_tdata = DATA_BITS'(out_value);

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for ns_tick_rate_converter_unit
// A directed table of conversions, then random words in both directions at
// several tick rates. Every output word is checked against its table entry or a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import ntrc_pkg::*;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int LATENCY = 68;

  typedef struct packed {
    logic [63:0] value;
    logic        sat;
  } conv_t;

  typedef struct {
    logic        op;
    logic [63:0] amount;
    logic        known;
    conv_t       res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  logic [39:0] rate_hz;
  conv_t expected_q[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;

  ns_tick_rate_converter_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor: conversion at the current rate
  function automatic conv_t convert(logic op, logic [63:0] amt, logic [39:0] hz_in);
    logic [63:0] hz, secs, rem, ticks, frac, prod, base, part;
    conv_t r;
    hz = {24'd0, hz_in};
    r.value = ALL_ONES;
    r.sat = 1'b1;
    if (op == OP_NS_TO_TICKS) begin
      if (amt == ALL_ONES) begin
        r.sat = 1'b0;
        return r;
      end
      secs = amt / NS_PER_SEC;
      rem = amt % NS_PER_SEC;
      if (hz != 0 && secs > ALL_ONES / hz) return r;
      ticks = secs * hz;
      frac = rem * (hz / NS_PER_SEC);
      prod = rem * (hz % NS_PER_SEC);
      frac = frac + prod / NS_PER_SEC + 64'((prod % NS_PER_SEC) != 0);
      if (frac > ALL_ONES - ticks) return r;
      r.value = ticks + frac;
      r.sat = 1'b0;
    end else begin
      if (hz == 0) return r;
      secs = amt / hz;
      rem = amt % hz;
      if (secs > ALL_ONES / NS_PER_SEC || rem > ALL_ONES / NS_PER_SEC) return r;
      base = secs * NS_PER_SEC;
      part = (rem * NS_PER_SEC) / hz;
      if (part > ALL_ONES - base) return r;
      r.value = base + part;
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // output checker and receiver stall
  always @(posedge clk) begin
    conv_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.value = m_tdata;
        got.sat = m_tuser;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h sat %b", got.value, got.sat);
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value || got.sat !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h/%b got %h/%b", want.value, want.sat,
                       got.value, got.sat);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_rate(logic [39:0] hz);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= hz;
    rate_hz = hz;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // one word on the input; predicted at acceptance
  task automatic send_word(logic op, logic [63:0] amt, logic known, conv_t res);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= amt;
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(known ? res : convert(op, amt, rate_hz));
  endtask

  function automatic logic [63:0] rand_amount();
    logic [63:0] a;
    a = {$urandom, $urandom};
    case ($urandom_range(5))
      0: a = a >> $urandom_range(63);
      1: a = ALL_ONES - 64'($urandom_range(3));
      2: a = 64'($urandom_range(2000000000));
      3: a = a & 64'h0000_00FF_FFFF_FFFF;
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [39:0] rand_rate();
    logic [39:0] h;
    h = 40'({$urandom, $urandom});
    case ($urandom_range(3))
      0: h = h >> $urandom_range(39);
      1: h = 40'($urandom_range(1000000000, 999000000));
      default: ;
    endcase
    return h;
  endfunction

  initial begin
    row_t dir[$];
    rate_hz = RATE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table at the reset rate of 1 GHz
    send_idle = 18;
    recv_idle = 86;
    dir.push_back('{OP_NS_TO_TICKS, 64'd0, 1'b1, '{64'd0, 1'b0}});
    dir.push_back('{OP_NS_TO_TICKS, ALL_ONES, 1'b1, '{ALL_ONES, 1'b0}});
    dir.push_back('{OP_NS_TO_TICKS, 64'd12345, 1'b1, '{64'd12345, 1'b0}});
    dir.push_back('{OP_TICKS_TO_NS, 64'd0, 1'b1, '{64'd0, 1'b0}});
    dir.push_back('{OP_TICKS_TO_NS, ALL_ONES, 1'b1, '{ALL_ONES, 1'b0}});
    dir.push_back('{OP_TICKS_TO_NS, 64'd777, 1'b1, '{64'd777, 1'b0}});
    dir.push_back('{OP_NS_TO_TICKS, ALL_ONES - 1, 1'b0, '0});
    foreach (dir[i]) send_word(dir[i].op, dir[i].amount, dir[i].known, dir[i].res);
    drain();

    // zero rate
    write_rate(40'd0);
    send_word(OP_NS_TO_TICKS, 64'd5000000000, 1'b1, '{64'd0, 1'b0});
    send_word(OP_TICKS_TO_NS, 64'd1, 1'b1, '{ALL_ONES, 1'b1});
    drain();
    // maximum rate: seconds overflow, leftover product too wide
    write_rate(40'hFF_FFFF_FFFF);
    send_word(OP_NS_TO_TICKS, ALL_ONES - 1, 1'b1, '{ALL_ONES, 1'b1});
    send_word(OP_NS_TO_TICKS, 64'd999999999, 1'b0, '0);
    send_word(OP_TICKS_TO_NS, 64'd18446744074, 1'b1, '{ALL_ONES, 1'b1});
    send_word(OP_TICKS_TO_NS, 64'd18446744073, 1'b0, '0);
    send_word(OP_TICKS_TO_NS, ALL_ONES, 1'b0, '0);
    drain();
    // rate 1 Hz: ticks-to-ns seconds overflow, ns rounding up
    write_rate(40'd1);
    send_word(OP_TICKS_TO_NS, 64'd18446744074, 1'b1, '{ALL_ONES, 1'b1});
    send_word(OP_TICKS_TO_NS, 64'd18446744073, 1'b0, '0);
    send_word(OP_NS_TO_TICKS, 64'd1, 1'b1, '{64'd1, 1'b0});
    send_word(OP_NS_TO_TICKS, 64'd1000000000, 1'b1, '{64'd1, 1'b0});
    drain();

    // random phases: rate changes only while drained
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 18 : (ph == 1) ? 86 : 0;
      recv_idle = (ph == 0) ? 86 : (ph == 1) ? 18 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        write_rate(rand_rate());
        for (int n = 0; n < 61; n++) begin
          send_word(1'($urandom_range(1)), rand_amount(), 1'b0, '0);
          // sender holds until the pipeline has emptied
          if (n == 30 && blk == 0) begin
            s_tvalid <= 1'b0;
            while (expected_q.size() != 0) @(posedge clk);
          end
        end
        drain();
      end
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
